[rtl/fcw_pkg.sv]
// fcw_pkg: shared types and constants for the cluster chain walker.
// Used by fcw_tables and fat_chain_walker; depends on nothing.

package fcw_pkg;

  // Entry masking and chain codes
  localparam int unsigned ENTRY_W        = 28;
  localparam int unsigned CLU_W          = 16;
  localparam int unsigned COUNT_W        = 16;
  localparam logic [27:0] END_LOW        = 28'h0FFF_FFF8;
  localparam logic [27:0] LINK_BAD       = 28'd1;
  localparam logic [27:0] LINK_FREE      = 28'd0;
  localparam logic [16:0] FIRST_CLUSTER  = 17'd2;
  localparam logic [15:0] TOTAL_CLU_RST  = 16'd65534;

  // Item kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_START_ZERO = 3'd1,
    ST_TOO_HIGH   = 3'd2,
    ST_DAMAGED    = 3'd3,
    ST_UNTERM     = 3'd4,
    ST_LOOP       = 3'd5
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_RESP
  } state_e;

  // Requests from the sequencer to the table memories
  typedef struct packed {
    logic        fat_we;
    logic [27:0] fat_wclu;
    logic [27:0] fat_wdata;
    logic        rd_en;
    logic [15:0] rd_clu;
    logic        map_we;   // mark the cluster of the last read
  } tbl_req_t;

  // Answers from the table memories
  typedef struct packed {
    logic [27:0] link;
    logic        marked;
    logic        clear_busy;
  } tbl_rsp_t;

endpackage

[rtl/fcw_tables.sv]
// fcw_tables: allocation table and used-cluster bitmap memories, with range
// masking and the bitmap clearing sweep after reset. Depends on fcw_pkg.

module fcw_tables #(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fcw_pkg::tbl_req_t req_i,
  output fcw_pkg::tbl_rsp_t rsp_o
);
  import fcw_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic [27:0] fat_mem [TABLE_ENTRIES];
  logic        map_mem [TABLE_ENTRIES];

  logic [27:0]   fat_rdata_q;
  logic          fat_ok_q;
  logic          map_rdata_q;
  logic          map_ok_q;
  logic [AW-1:0] map_idx_q;
  logic [AW-1:0] clr_q;
  logic          clr_busy_q;

  logic [31:0] rd_clu_w;
  logic [31:0] map_idx_w;
  logic [31:0] wr_clu_w;
  logic        fat_rd_ok;
  logic        map_rd_ok;
  logic        fat_wr_ok;

  // Range checks on the cluster numbers
  always_comb begin
    rd_clu_w  = {16'd0, req_i.rd_clu};
    map_idx_w = rd_clu_w - {15'd0, FIRST_CLUSTER};
    wr_clu_w  = {4'd0, req_i.fat_wclu};
    fat_rd_ok = rd_clu_w < 32'(TABLE_ENTRIES);
    map_rd_ok = (rd_clu_w >= {15'd0, FIRST_CLUSTER}) && (map_idx_w < 32'(TABLE_ENTRIES));
    fat_wr_ok = wr_clu_w < 32'(TABLE_ENTRIES);
  end

  // Allocation table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.fat_we && fat_wr_ok) begin
      fat_mem[wr_clu_w[AW-1:0]] <= req_i.fat_wdata;
    end
    if (req_i.rd_en) begin
      fat_rdata_q <= fat_mem[rd_clu_w[AW-1:0]];
    end
  end

  // Bitmap: clearing sweep takes the write port first, then marking
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      map_mem[clr_q] <= 1'b0;
    end else if (req_i.map_we && map_ok_q) begin
      map_mem[map_idx_q] <= 1'b1;
    end
    if (req_i.rd_en) begin
      map_rdata_q <= map_mem[map_idx_w[AW-1:0]];
      map_idx_q   <= map_idx_w[AW-1:0];
    end
  end

  // Range flags that travel with the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_ok_q <= 1'b0;
      map_ok_q <= 1'b0;
    end else if (req_i.rd_en) begin
      fat_ok_q <= fat_rd_ok;
      map_ok_q <= map_rd_ok;
    end
  end

  // Clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(TABLE_ENTRIES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Out-of-table reads give link 0 and an unmarked bit
  always_comb begin
    rsp_o.link       = fat_ok_q ? fat_rdata_q : LINK_FREE;
    rsp_o.marked     = map_ok_q & map_rdata_q;
    rsp_o.clear_busy = clr_busy_q;
  end

endmodule

[rtl/fat_chain_walker.sv]
// fat_chain_walker: top level of the FAT32 cluster chain checker.
// Depends on fcw_pkg and fcw_tables.
//
//   channel   direction  handshake               payload
//   in        to block   in_valid_i/in_ready_o   action_i, cluster_i, entry_value_i
//   out       from block out_valid_o/out_ready_i status_o, chain_length_o,
//                                                crosslink_count_o, first_crosslink_o
//   cfg       to block   cfg_valid_i/cfg_ready_o cfg_data_i (total_clusters)
//
// A table write or a rejected start goes from the idle state to the response state,
// where its result is loaded into the result register. A chain check makes, for
// each visited cluster, a table read and then an evaluate and mark step through the
// single bitmap port. After reset the bitmap is swept to zero; no item is taken
// meanwhile, configuration writes are. A waiting result does not block the next
// input transfer; the result register is reloaded once it has been taken.

module fat_chain_walker #(
  parameter int unsigned TABLE_ENTRIES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [27:0] cluster_i,
  input  logic [31:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] chain_length_o,
  output logic [15:0] crosslink_count_o,
  output logic [27:0] first_crosslink_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import fcw_pkg::*;

  state_e      state_q, state_d;
  status_e     stat_q;
  logic [15:0] tc_q;
  logic [15:0] cur_q;
  logic [15:0] len_q;
  logic [15:0] xcnt_q;
  logic [27:0] xfirst_q;

  logic        out_valid_q;
  status_e     out_stat_q;
  logic [15:0] out_len_q;
  logic [15:0] out_xcnt_q;
  logic [27:0] out_xfirst_q;

  tbl_req_t    tbl_req;
  tbl_rsp_t    tbl_rsp;

  logic        in_xfer;
  logic        out_load;
  logic [16:0] limit;
  logic        start_zero;
  logic        start_high;
  logic [15:0] len_inc;
  logic        ev_stop;
  logic        ev_count;
  status_e     ev_status;

  fcw_tables #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_tables (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (tbl_req),
    .rsp_o (tbl_rsp)
  );

  // Configuration register, taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= TOTAL_CLU_RST;
    end else if (cfg_valid_i) begin
      tc_q <= cfg_data_i;
    end
  end

  // Handshakes
  assign in_ready_o = (state_q == S_IDLE) && !tbl_rsp.clear_busy;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Start checks
  always_comb begin
    limit      = {1'b0, tc_q} + FIRST_CLUSTER;
    start_zero = cluster_i == 28'd0;
    start_high = cluster_i >= {11'd0, limit};
  end

  // Link evaluation on the read data
  always_comb begin
    len_inc   = len_q + 16'd1;
    ev_stop   = 1'b1;
    ev_count  = 1'b1;
    ev_status = ST_OK;
    if (tbl_rsp.link >= END_LOW) begin
      ev_status = ST_OK;
    end else if ((tbl_rsp.link == LINK_BAD) || (tbl_rsp.link >= {11'd0, limit})) begin
      ev_status = ST_DAMAGED;
      ev_count  = 1'b0;
    end else if (tbl_rsp.link == LINK_FREE) begin
      ev_status = ST_UNTERM;
    end else if (len_inc >= tc_q) begin
      ev_status = ST_LOOP;
    end else begin
      ev_stop = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if ((action_i == ACT_CHECK) && !start_zero && !start_high) begin
            state_d = S_READ;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: state_d = ev_stop ? S_RESP : S_READ;
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Table requests and result loading
  always_comb begin
    tbl_req.fat_we    = 1'b0;
    tbl_req.fat_wclu  = cluster_i;
    tbl_req.fat_wdata = entry_value_i[27:0];
    tbl_req.rd_en     = 1'b0;
    tbl_req.rd_clu    = cur_q;
    tbl_req.map_we    = 1'b0;
    out_load          = 1'b0;
    case (state_q)
      S_IDLE: tbl_req.fat_we = in_xfer && (action_i == ACT_WRITE);
      S_READ: tbl_req.rd_en  = 1'b1;
      S_EVAL: tbl_req.map_we = 1'b1;
      S_RESP: out_load       = !out_valid_q || out_ready_i;
      default: out_load      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cur_q    <= cluster_i[15:0];
          len_q    <= '0;
          xcnt_q   <= '0;
          xfirst_q <= '0;
          if (action_i == ACT_WRITE) begin
            stat_q <= ST_OK;
          end else if (start_zero) begin
            stat_q <= ST_START_ZERO;
          end else if (start_high) begin
            stat_q <= ST_TOO_HIGH;
          end else begin
            stat_q <= ST_OK;
          end
        end
      end
      S_EVAL: begin
        if (tbl_rsp.marked) begin
          xcnt_q <= xcnt_q + 16'd1;
          if (xcnt_q == 16'd0) begin
            xfirst_q <= {12'd0, cur_q};
          end
        end
        if (ev_count) begin
          len_q <= len_inc;
        end
        stat_q <= ev_status;
        cur_q  <= tbl_rsp.link[15:0];
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q   <= stat_q;
      out_len_q    <= len_q;
      out_xcnt_q   <= xcnt_q;
      out_xfirst_q <= xfirst_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_stat_q;
  assign chain_length_o    = out_len_q;
  assign crosslink_count_o = out_xcnt_q;
  assign first_crosslink_o = out_xfirst_q;

  // Checks
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> ($past(state_q) == S_READ))
    else $error("evaluate without a preceding table read");

  a_load_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("result register loaded outside the response state");

  a_no_walk_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_rsp.clear_busy |-> (state_q == S_IDLE))
    else $error("item in progress during the bitmap sweep");

  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_stat_q == ST_START_ZERO) || (out_stat_q == ST_TOO_HIGH)))
      |-> ((out_len_q == 16'd0) && (out_xcnt_q == 16'd0)))
    else $error("rejected start reports a walk");

  a_xlink_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_xcnt_q == 16'd0) == (out_xfirst_q == 28'd0)))
    else $error("cross-link count and first cross-link disagree");

endmodule
